// ----- rtl/kst_pkg.sv -----
package kst_pkg;

	localparam int unsigned REQ_W    = 2;
	localparam int unsigned KEY_W    = 16;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned STAT_W   = 3;
	localparam int unsigned S_DATA_W = 56;
	localparam int unsigned M_DATA_W = 40;
	localparam int unsigned S_USER_W = 2;
	localparam int unsigned M_USER_W = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_CREATE = 2'd0,
		REQ_PUSH   = 2'd1,
		REQ_POP    = 2'd2,
		REQ_REMOVE = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_EXISTS  = 3'd1,
		STAT_NO_SLOT = 3'd2,
		STAT_NO_KEY  = 3'd3,
		STAT_FULL    = 3'd4,
		STAT_EMPTY   = 3'd5
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic capture_pop;
	} cmd_t;

	typedef struct packed {
		logic pop_hit;
	} dp_stat_t;

endpackage

// ----- rtl/kst_ram.sv -----
module kst_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/kst_ctrl.sv -----
module kst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output kst_pkg::cmd_t     cmd,
	input  kst_pkg::dp_stat_t stat
);

	kst_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kst_pkg::ST_IDLE: begin
				if (in_valid) state_d = kst_pkg::ST_EXEC;
			end
			kst_pkg::ST_EXEC: begin
				state_d = stat.pop_hit ? kst_pkg::ST_READ : kst_pkg::ST_RESP;
			end
			kst_pkg::ST_READ: begin
				state_d = kst_pkg::ST_RESP;
			end
			kst_pkg::ST_RESP: begin
				if (out_ready) state_d = kst_pkg::ST_IDLE;
			end
			default: begin
				state_d = kst_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		out_valid       = 1'b0;
		cmd.load        = 1'b0;
		cmd.exec        = 1'b0;
		cmd.capture_pop = 1'b0;
		unique case (state_q)
			kst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			kst_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			kst_pkg::ST_READ: begin
				cmd.capture_pop = 1'b1;
			end
			kst_pkg::ST_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/kst_dp.sv -----
module kst_dp #(
	parameter int unsigned NUM_STACKS  = 4,
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kst_pkg::cmd_t                cmd,
	output kst_pkg::dp_stat_t            stat,
	input  kst_pkg::req_t                req_type,
	input  logic [kst_pkg::KEY_W-1:0]    stack_key,
	input  logic [kst_pkg::VAL_W-1:0]    push_value,
	input  logic [kst_pkg::CNT_W-1:0]    capacity,
	output kst_pkg::stat_t               status,
	output logic [kst_pkg::VAL_W-1:0]    pop_value,
	output logic [kst_pkg::CNT_W-1:0]    depth_now
);

	localparam int unsigned SW      = NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1;
	localparam int unsigned MEM_DEP = NUM_STACKS * STACK_DEPTH;
	localparam int unsigned AW      = MEM_DEP > 1 ? $clog2(MEM_DEP) : 1;
	localparam int unsigned CMP_W   = 9;

	// slot table
	logic                      slot_used_q [NUM_STACKS];
	logic [kst_pkg::KEY_W-1:0] slot_key_q  [NUM_STACKS];
	logic [kst_pkg::CNT_W-1:0] slot_cap_q  [NUM_STACKS];
	logic [kst_pkg::CNT_W-1:0] slot_cnt_q  [NUM_STACKS];

	// held request
	kst_pkg::req_t             req_q;
	logic [kst_pkg::KEY_W-1:0] key_q;
	logic [kst_pkg::VAL_W-1:0] val_q;
	logic [kst_pkg::CNT_W-1:0] cap_q;

	// result
	kst_pkg::stat_t            status_q;
	logic [kst_pkg::VAL_W-1:0] pop_q;
	logic [kst_pkg::CNT_W-1:0] depth_q;

	logic                      hit_any, free_any;
	logic [SW-1:0]             hit_idx, free_idx;
	logic [kst_pkg::CNT_W-1:0] hit_cnt, hit_cap, cap_clamp, elem_idx;
	logic                      do_create, do_push, do_pop, do_remove;
	kst_pkg::stat_t            status_d;
	logic [kst_pkg::CNT_W-1:0] depth_d;
	logic [AW-1:0]             mem_addr;
	logic [kst_pkg::VAL_W-1:0] ram_rdata;

	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = 0; i < NUM_STACKS; i++) begin
			if (slot_used_q[i] && slot_key_q[i] == key_q) begin
				hit_any = 1'b1;
				hit_idx = SW'(i);
			end
		end
		// lowest free slot wins
		for (int i = NUM_STACKS - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign hit_cnt   = slot_cnt_q[hit_idx];
	assign hit_cap   = slot_cap_q[hit_idx];
	assign cap_clamp = (CMP_W'(cap_q) > CMP_W'(STACK_DEPTH)) ? kst_pkg::CNT_W'(STACK_DEPTH)
	                                                         : cap_q;

	always_comb begin
		do_create = 1'b0;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		do_remove = 1'b0;
		status_d  = kst_pkg::STAT_OK;
		depth_d   = '0;
		unique case (req_q)
			kst_pkg::REQ_CREATE: begin
				if (hit_any) begin
					status_d = kst_pkg::STAT_EXISTS;
					depth_d  = hit_cnt;
				end else if (free_any) begin
					do_create = 1'b1;
				end else begin
					status_d = kst_pkg::STAT_NO_SLOT;
				end
			end
			kst_pkg::REQ_PUSH: begin
				if (!hit_any) begin
					status_d = kst_pkg::STAT_NO_KEY;
				end else if (hit_cnt >= hit_cap) begin
					status_d = kst_pkg::STAT_FULL;
					depth_d  = hit_cnt;
				end else begin
					do_push = 1'b1;
					depth_d = hit_cnt + 1'b1;
				end
			end
			kst_pkg::REQ_POP: begin
				if (!hit_any) begin
					status_d = kst_pkg::STAT_NO_KEY;
				end else if (hit_cnt == '0) begin
					status_d = kst_pkg::STAT_EMPTY;
				end else begin
					do_pop  = 1'b1;
					depth_d = hit_cnt - 1'b1;
				end
			end
			kst_pkg::REQ_REMOVE: begin
				if (!hit_any) begin
					status_d = kst_pkg::STAT_NO_KEY;
				end else begin
					do_remove = 1'b1;
				end
			end
			default: begin
				status_d = kst_pkg::STAT_OK;
			end
		endcase
	end

	// push writes at the count, pop reads one below it
	assign elem_idx = do_pop ? hit_cnt - 1'b1 : hit_cnt;
	assign mem_addr = AW'(hit_idx) * AW'(STACK_DEPTH) + AW'(elem_idx);

	assign stat.pop_hit = cmd.exec && do_pop;

	kst_ram #(
		.WIDTH(kst_pkg::VAL_W),
		.DEPTH(MEM_DEP)
	) u_elem_ram (
		.clk   (clk),
		.we    (cmd.exec && do_push),
		.waddr (mem_addr),
		.wdata (val_q),
		.re    (cmd.exec && do_pop),
		.raddr (mem_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				slot_used_q[i] <= 1'b0;
				slot_key_q[i]  <= '0;
				slot_cap_q[i]  <= '0;
				slot_cnt_q[i]  <= '0;
			end
		end else if (cmd.exec) begin
			if (do_create) begin
				slot_used_q[free_idx] <= 1'b1;
				slot_key_q[free_idx]  <= key_q;
				slot_cap_q[free_idx]  <= cap_clamp;
				slot_cnt_q[free_idx]  <= '0;
			end
			if (do_push || do_pop) begin
				slot_cnt_q[hit_idx] <= depth_d;
			end
			if (do_remove) begin
				slot_used_q[hit_idx] <= 1'b0;
				slot_key_q[hit_idx]  <= '0;
				slot_cap_q[hit_idx]  <= '0;
				slot_cnt_q[hit_idx]  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= stack_key;
			val_q <= push_value;
			cap_q <= capacity;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			depth_q  <= depth_d;
			pop_q    <= '0;
		end
		if (cmd.capture_pop) begin
			pop_q <= ram_rdata;
		end
	end

	assign status    = status_q;
	assign pop_value = pop_q;
	assign depth_now = depth_q;

endmodule

// ----- rtl/keyed_stack_table_core.sv -----
// channel  dir  tdata (low bit up)                                 tuser
// s_*      in   stack_key[15:0] push_value[47:16] capacity[52:48]  req_type[1:0]
// m_*      out  pop_value[31:0] depth_now[36:32]                   status[2:0]
//
// One request in flight: accept, execute, then the result word is held on m_*.
// Each request passes through accept, execute and result; a pop that returns a
// value adds a read state (registered read of the element RAM) before the result.
// The result word is registered and valid on m_* in the result state.
// Reset clears the slot table only; element RAM is not cleared and needs no pass.
// A stalled result holds until m_tready; s_tready stays low meanwhile.
module keyed_stack_table_core #(
	parameter int unsigned NUM_STACKS  = 4,
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [kst_pkg::S_DATA_W-1:0]  s_tdata,  // stack_key, push_value, capacity
	input  logic [kst_pkg::S_USER_W-1:0]  s_tuser,  // req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [kst_pkg::M_DATA_W-1:0]  m_tdata,  // pop_value, depth_now
	output logic [kst_pkg::M_USER_W-1:0]  m_tuser   // status
);

	kst_pkg::cmd_t             cmd;
	kst_pkg::dp_stat_t         stat;
	kst_pkg::stat_t            status;
	logic [kst_pkg::VAL_W-1:0] pop_value;
	logic [kst_pkg::CNT_W-1:0] depth_now;

	kst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	kst_dp #(
		.NUM_STACKS (NUM_STACKS),
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (kst_pkg::req_t'(s_tuser)),
		.stack_key  (s_tdata[15:0]),
		.push_value (s_tdata[47:16]),
		.capacity   (s_tdata[52:48]),
		.status     (status),
		.pop_value  (pop_value),
		.depth_now  (depth_now)
	);

	assign m_tdata = {3'b000, depth_now, pop_value};
	assign m_tuser = status;

endmodule
